@@ sv/rbtgc_pkg.sv @@
package rbtgc_pkg;

    localparam int BLOCKS_DEF    = 32;
    localparam int SIZE_BITS_DEF = 16;
    localparam int REF_BITS_DEF  = 8;

    localparam int TOTAL_W  = 21;
    localparam int ID_W     = 6;
    localparam int REFOUT_W = 8;
    localparam int SIZEIN_W = 16;
    localparam int STATUS_W = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [TOTAL_W-1:0] THRESH_RESET = 21'd400;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_ADD     = 2'd1,
        FN_REMOVE  = 2'd2,
        FN_COLLECT = 2'd3
    } func_t;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_NEEDED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_start;
        logic sweep_read;
        logic sweep_free;
        logic sweep_next;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic collect;
        logic need_sweep;
        logic cur_live;
        logic cur_zero;
        logic last_slot;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

@@ sv/rbtgc_ctrl.sv @@
module rbtgc_ctrl
    import rbtgc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SW_RD,
        S_SW_CHK,
        S_SW_END
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.collect && stat.need_sweep) begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SW_RD;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SW_RD: begin
                if (stat.cur_live) begin
                    cmd.sweep_read = 1'b1;
                    state_next     = S_SW_CHK;
                end else if (stat.last_slot) begin
                    state_next = S_SW_END;
                end else begin
                    cmd.sweep_next = 1'b1;
                end
            end
            S_SW_CHK: begin
                if (stat.cur_zero) begin
                    if (!stat.pend_valid || stat.out_free) begin
                        cmd.sweep_free = 1'b1;
                        if (stat.last_slot) begin
                            state_next = S_SW_END;
                        end else begin
                            cmd.sweep_next = 1'b1;
                            state_next     = S_SW_RD;
                        end
                    end
                end else if (stat.last_slot) begin
                    state_next = S_SW_END;
                end else begin
                    cmd.sweep_next = 1'b1;
                    state_next     = S_SW_RD;
                end
            end
            S_SW_END: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/rbtgc_dp.sv @@
module rbtgc_dp
    import rbtgc_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int REF_BITS  = REF_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [23:0]        s_tdata,       // alloc_size, block_id
    input  logic [1:0]         s_tuser,       // func
    input  logic [TOTAL_W-1:0] gc_threshold,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,       // result_id, ref_count, used_total
    output logic [2:0]         m_tuser,       // status
    output logic               m_tlast
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 2);
    localparam int SUM_W = $clog2(BLOCKS + 1) + SIZE_BITS;
    localparam int TOT_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int CMP_W = 8;

    function automatic logic [TOTAL_W-1:0] sat_tot(input logic [TOT_W-1:0] v);
        logic [TOTAL_W-1:0] r;
        if (v > TOT_W'(TOTAL_MAX)) begin
            r = TOTAL_MAX;
        end else begin
            r = v[TOTAL_W-1:0];
        end
        return r;
    endfunction

    // input unpack
    logic [SIZEIN_W-1:0]           in_size;
    logic [ID_W-1:0]               in_id;
    logic [ID_W-1:0]               in_id_m1;
    logic [SIZE_BITS+SIZEIN_W-1:0] in_size_wide;

    assign in_size      = s_tdata[15:0];
    assign in_id        = s_tdata[21:16];
    assign in_id_m1     = in_id - ID_W'(1);
    assign in_size_wide = {{SIZE_BITS{1'b0}}, in_size};

    func_t                func_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [ID_W-1:0]      id_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(s_tuser);
            size_reg <= in_size_wide[SIZE_BITS-1:0];
            id_reg   <= in_id;
        end
    end

    // table state
    logic [BLOCKS-1:0]   live_reg;
    logic [CNT_W-1:0]    next_slot_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [IDX_W-1:0]    k_reg;
    logic                pend_valid_reg;
    logic [ID_W-1:0]     pend_id_reg;
    logic [TOTAL_W-1:0]  pend_total_reg;

    // slot memories
    logic [SIZE_BITS-1:0] size_mem [BLOCKS];
    logic [REF_BITS-1:0]  refs_mem [BLOCKS];
    logic [SIZE_BITS-1:0] size_rd_reg;
    logic [REF_BITS-1:0]  refs_rd_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 rd_en;

    assign rd_addr = cmd.load ? in_id_m1[IDX_W-1:0] : k_reg;
    assign rd_en   = cmd.load | cmd.sweep_read;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            size_rd_reg <= size_mem[rd_addr];
            refs_rd_reg <= refs_mem[rd_addr];
        end
    end

    // operation decode
    logic [ID_W-1:0]               id_m1;
    logic [IDX_W-1:0]              id_idx;
    logic [CNT_W-1:0]              ns_m1;
    logic [IDX_W-1:0]              ns_idx;
    logic                          found;
    logic                          full;
    logic [REF_BITS-1:0]           refs_upd;
    logic [TOT_W-1:0]              alloc_total;
    logic [TOT_W-1:0]              free_total;
    logic [CNT_W+ID_W-1:0]         ns_wide;
    logic [CNT_W:0]                k_p1;
    logic [CNT_W+ID_W:0]           k_wide;
    logic [REF_BITS+REFOUT_W-1:0]  refs_wide;

    assign id_m1       = id_reg - ID_W'(1);
    assign id_idx      = id_m1[IDX_W-1:0];
    assign ns_m1       = next_slot_reg - CNT_W'(1);
    assign ns_idx      = ns_m1[IDX_W-1:0];
    assign full        = CMP_W'(next_slot_reg) > CMP_W'(BLOCKS);
    assign found       = (id_reg != '0) && (CMP_W'(id_reg) <= CMP_W'(BLOCKS))
                         && (CMP_W'(id_reg) < CMP_W'(next_slot_reg)) && live_reg[id_idx];
    assign alloc_total = total_reg + TOT_W'(size_reg);
    assign free_total  = total_reg - TOT_W'(size_rd_reg);
    assign ns_wide     = {{ID_W{1'b0}}, next_slot_reg};
    assign k_p1        = (CNT_W + 1)'(k_reg) + (CNT_W + 1)'(1);
    assign k_wide      = {{ID_W{1'b0}}, k_p1};
    assign refs_wide   = {{REFOUT_W{1'b0}}, refs_upd};

    always_comb begin
        refs_upd = refs_rd_reg;
        if (func_reg == FN_ADD) begin
            if (refs_rd_reg != '1) begin
                refs_upd = refs_rd_reg + REF_BITS'(1);
            end
        end else if (refs_rd_reg != '0) begin
            refs_upd = refs_rd_reg - REF_BITS'(1);
        end
    end

    // memory writes
    logic size_we;
    logic refs_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [REF_BITS-1:0] refs_wdata;

    always_comb begin
        size_we    = 1'b0;
        refs_we    = 1'b0;
        wr_addr    = ns_idx;
        refs_wdata = REF_BITS'(1);
        if (cmd.exec) begin
            case (func_reg) inside
                FN_ALLOC: begin
                    size_we = !full;
                    refs_we = !full;
                end
                FN_ADD, FN_REMOVE: begin
                    refs_we    = found;
                    wr_addr    = id_idx;
                    refs_wdata = refs_upd;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[wr_addr] <= size_reg;
        end
        if (refs_we) begin
            refs_mem[wr_addr] <= refs_wdata;
        end
    end

    // result select
    logic                   out_load;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_id;
    logic [REFOUT_W-1:0]    o_refs;
    logic [TOTAL_W-1:0]     o_total;
    logic                   o_last;

    assign out_load = cmd.exec | cmd.finish | (cmd.sweep_free & pend_valid_reg);

    always_comb begin
        o_status = ST_OK;
        o_id     = '0;
        o_refs   = '0;
        o_total  = sat_tot(total_reg);
        o_last   = 1'b1;
        if (cmd.exec) begin
            case (func_reg) inside
                FN_ALLOC: begin
                    if (full) begin
                        o_status = ST_FULL;
                    end else begin
                        o_id    = ns_wide[ID_W-1:0];
                        o_refs  = REFOUT_W'(1);
                        o_total = sat_tot(alloc_total);
                    end
                end
                FN_ADD, FN_REMOVE: begin
                    if (found) begin
                        o_id   = id_reg;
                        o_refs = refs_wide[REFOUT_W-1:0];
                    end else begin
                        o_status = ST_UNKNOWN;
                    end
                end
                default: o_status = ST_NOT_NEEDED;
            endcase
        end else if (cmd.finish) begin
            if (pend_valid_reg) begin
                o_id    = pend_id_reg;
                o_total = pend_total_reg;
            end else begin
                o_status = ST_NONE;
            end
        end else begin
            o_id    = pend_id_reg;
            o_total = pend_total_reg;
            o_last  = 1'b0;
        end
    end

    // table and sweep state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg       <= '0;
            next_slot_reg  <= CNT_W'(1);
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            k_reg          <= '0;
        end else begin
            if (cmd.exec && func_reg == FN_ALLOC && !full) begin
                live_reg[ns_idx] <= 1'b1;
                next_slot_reg    <= next_slot_reg + CNT_W'(1);
                total_reg        <= alloc_total;
            end
            if (cmd.sweep_start) begin
                k_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.sweep_free) begin
                live_reg[k_reg] <= 1'b0;
                total_reg       <= free_total;
                pend_valid_reg  <= 1'b1;
            end
            if (cmd.sweep_next) begin
                k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep_free) begin
            pend_id_reg    <= k_wide[ID_W-1:0];
            pend_total_reg <= sat_tot(free_total);
        end
    end

    // output register
    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic [REFOUT_W-1:0]    m_refs_reg;
    logic [TOTAL_W-1:0]     m_total_reg;
    logic                   m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= o_status;
            m_id_reg     <= o_id;
            m_refs_reg   <= o_refs;
            m_total_reg  <= o_total;
            m_last_reg   <= o_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_total_reg, m_refs_reg, m_id_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    assign stat.collect    = (func_reg == FN_COLLECT);
    assign stat.need_sweep = total_reg > TOT_W'(gc_threshold);
    assign stat.cur_live   = live_reg[k_reg];
    assign stat.cur_zero   = (refs_rd_reg == '0);
    assign stat.last_slot  = (k_reg == IDX_W'(BLOCKS - 1));
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule

@@ sv/refcount_block_table_gc_top.sv @@
// allocate, add and remove reference: request registered, then result in the
// output register; no new request before that, nor while the result side stalls
// collect: one memory read per live slot, through the single read port of the
// slot tables; one result per freed block, or a single status result when no
// block is freed or no sweep is needed
// reset: live bits and total cleared, next id 1, gc_threshold 400; no clearing pass
module refcount_block_table_gc_top
    import rbtgc_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int REF_BITS  = REF_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // alloc_size, block_id
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_id, ref_count, used_total
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TOTAL_W-1:0] thresh_reg;
    logic               cfg_wr;
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;

    // single register, every address maps to it
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == paddr);
    assign pready = 1'b1;
    assign prdata = {{(32 - TOTAL_W){1'b0}}, thresh_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr) begin
            thresh_reg <= pwdata[TOTAL_W-1:0];
        end
    end

    rbtgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbtgc_dp #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS),
        .REF_BITS  (REF_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .gc_threshold (thresh_reg),
        .cmd          (cmd),
        .stat         (stat),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

@@ tb/rbtgc_checker.sv @@
module rbtgc_checker
    import rbtgc_pkg::*;
#(
    parameter logic [1:0] THRESH_ADDR = 2'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // alloc_size, block_id
    input  logic [1:0]  s_tuser,   // func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // result_id, ref_count, used_total
    input  logic [2:0]  m_tuser,   // status
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = BLOCKS_DEF;
    localparam logic [REFOUT_W-1:0] REF_TOP = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [REFOUT_W-1:0] refs;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } gc_result_t;

    gc_result_t          expected_results[$];
    logic [SIZEIN_W-1:0] blk_size[NBLK];
    logic [REFOUT_W-1:0] blk_refs[NBLK];
    logic [NBLK-1:0]     blk_live;
    int unsigned         next_id;
    int unsigned         used_sum;
    logic [TOTAL_W-1:0]  threshold;
    int                  errors;
    gc_result_t          got;
    gc_result_t          exp_res;

    function automatic logic [TOTAL_W-1:0] sat_total(input int unsigned t);
        return (t > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(t);
    endfunction

    task automatic post(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] id,
                        input logic [REFOUT_W-1:0] refs, input logic last);
        gc_result_t r;
        r.status = st;
        r.id     = id;
        r.refs   = refs;
        r.total  = sat_total(used_sum);
        r.last   = last;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic block_table_step(input func_t fn, input logic [SIZEIN_W-1:0] sz,
                                    input logic [ID_W-1:0] bid);
        int slot;
        int k;
        int sweep_q[$];
        slot = -1;
        case (fn)
            FN_ALLOC: begin
                if (next_id > NBLK) begin
                    post(ST_FULL, '0, '0, 1'b1);
                end else begin
                    slot = int'(next_id) - 1;
                    blk_size[slot] = sz;
                    blk_refs[slot] = 8'd1;
                    blk_live[slot] = 1'b1;
                    used_sum += sz;
                    post(ST_OK, ID_W'(next_id), 8'd1, 1'b1);
                    next_id++;
                end
            end
            FN_ADD, FN_REMOVE: begin
                if (bid != '0 && int'(bid) <= NBLK && int'(bid) < int'(next_id) &&
                    blk_live[int'(bid) - 1]) begin
                    slot = int'(bid) - 1;
                end
                if (slot < 0) begin
                    post(ST_UNKNOWN, '0, '0, 1'b1);
                end else begin
                    if (fn == FN_ADD) begin
                        if (blk_refs[slot] != REF_TOP) blk_refs[slot]++;
                    end else if (blk_refs[slot] != '0) begin
                        blk_refs[slot]--;
                    end
                    post(ST_OK, ID_W'(slot + 1), blk_refs[slot], 1'b1);
                end
            end
            FN_COLLECT: begin
                if (used_sum <= threshold) begin
                    post(ST_NOT_NEEDED, '0, '0, 1'b1);
                end else begin
                    for (k = 0; k < NBLK; k++) begin
                        if (blk_live[k] && blk_refs[k] == '0) sweep_q.insert(sweep_q.size(), k);
                    end
                    if (sweep_q.size() == 0) begin
                        post(ST_NONE, '0, '0, 1'b1);
                    end else begin
                        foreach (sweep_q[i]) begin
                            blk_live[sweep_q[i]] = 1'b0;
                            used_sum -= blk_size[sweep_q[i]];
                            post(ST_OK, ID_W'(sweep_q[i] + 1), '0, i == sweep_q.size() - 1);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            blk_live  = '0;
            next_id   = 1;
            used_sum  = 0;
            threshold = THRESH_RESET;
            errors    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.id     = m_tdata[5:0];
                got.refs   = m_tdata[13:6];
                got.total  = m_tdata[34:14];
                got.last   = m_tlast;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer status=%0d id=%0d refs=%0d total=%0d last=%0b",
                             $time, got.status, got.id, got.refs, got.total, got.last);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res) begin
                        $display("%0t: result mismatch expected status=%0d id=%0d refs=%0d total=%0d last=%0b",
                                 $time, exp_res.status, exp_res.id, exp_res.refs, exp_res.total,
                                 exp_res.last);
                        $display("%0t:                 actual   status=%0d id=%0d refs=%0d total=%0d last=%0b",
                                 $time, got.status, got.id, got.refs, got.total, got.last);
                        errors++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == THRESH_ADDR) begin
                threshold = pwdata[TOTAL_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                block_table_step(func_t'(s_tuser), s_tdata[15:0], s_tdata[21:16]);
            end
        end
        fail_count      <= errors;
        results_pending <= expected_results.size();
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top
    import rbtgc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]         ADDR_GC_THRESHOLD = 2'd0;
    localparam logic [TOTAL_W-1:0] THRESH_TOP        = 21'd2097120;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // alloc_size, block_id
    logic [1:0]  s_tuser  = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // result_id, ref_count, used_total
    logic [2:0]  m_tuser;         // status
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int results_pending;
    bit idle_enable = 1'b1;
    int rx_hold     = 0;
    int ids_handed  = 0;

    refcount_block_table_gc_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rbtgc_checker #(
        .THRESH_ADDR (ADDR_GC_THRESHOLD)
    ) i_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side stall bursts
    always @(posedge aclk) begin
        if (!idle_enable) begin
            m_tready <= 1'b1;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
            rx_hold  <= $urandom_range(0, 14);
        end
    end

    task automatic send_op(input func_t fn, input logic [SIZEIN_W-1:0] sz,
                           input logic [ID_W-1:0] bid);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {2'b00, bid, sz};
        if (fn == FN_ALLOC && ids_handed < BLOCKS_DEF) ids_handed++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic write_threshold(input logic [TOTAL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GC_THRESHOLD;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_ops(input int count);
        int r;
        func_t fn;
        logic [SIZEIN_W-1:0] sz;
        logic [ID_W-1:0] bid;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 22)      fn = FN_ALLOC;
            else if (r < 45) fn = FN_ADD;
            else if (r < 80) fn = FN_REMOVE;
            else             fn = FN_COLLECT;
            sz = SIZEIN_W'($urandom_range(0, 65535));
            case ($urandom_range(0, 3))
                0: sz = {8'h00, sz[7:0]};
                1: sz = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default: ;
            endcase
            if (ids_handed == 0 || $urandom_range(0, 11) == 0) begin
                bid = ID_W'($urandom_range(0, 32));
            end else begin
                bid = ID_W'($urandom_range(1, ids_handed));
            end
            send_op(fn, sz, bid);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, unknown ids, first blocks
        send_op(FN_COLLECT, '0, '0);
        send_op(FN_ADD, '0, 6'd0);
        send_op(FN_REMOVE, '0, 6'd5);
        send_op(FN_ADD, '0, 6'd32);
        send_op(FN_ALLOC, 16'd0, '0);
        send_op(FN_ALLOC, 16'hFFFF, '0);
        send_op(FN_ALLOC, 16'd100, '0);
        send_op(FN_REMOVE, '0, 6'd1);
        send_op(FN_REMOVE, '0, 6'd1);
        send_op(FN_ADD, '0, 6'd3);
        send_op(FN_COLLECT, '0, '0);
        send_op(FN_ADD, '0, 6'd1);
        send_op(FN_COLLECT, '0, '0);
        send_op(FN_REMOVE, '0, 6'd2);
        send_op(FN_REMOVE, '0, 6'd3);
        send_op(FN_REMOVE, '0, 6'd3);
        send_op(FN_COLLECT, '0, '0);
        wait_drained();

        write_threshold('0);
        send_op(FN_COLLECT, '0, '0);
        send_op(FN_ALLOC, 16'd63, '0);
        // a few references on one block
        repeat (3) send_op(FN_ADD, '0, 6'd4);
        send_op(FN_REMOVE, '0, 6'd4);
        send_op(FN_REMOVE, '0, 6'd4);
        send_op(FN_COLLECT, '0, '0);
        send_op(FN_ALLOC, 16'd5, '0);
        send_op(FN_REMOVE, '0, 6'd5);
        send_op(FN_COLLECT, '0, '0);
        wait_drained();

        write_threshold(THRESH_TOP);
        send_op(FN_ALLOC, 16'd1, '0);
        send_op(FN_REMOVE, '0, 6'd6);
        send_op(FN_COLLECT, '0, '0);
        wait_drained();

        write_threshold(TOTAL_W'($urandom_range(1000, 200000)));
        random_ops(40);
        wait_drained();
        write_threshold(THRESH_TOP);
        random_ops(35);
        wait_drained();
        write_threshold(TOTAL_W'($urandom_range(0, 2097120)));
        random_ops(40);
        wait_drained();
        write_threshold('0);
        random_ops(35);
        wait_drained();
        idle_enable <= 1'b0;
        write_threshold(THRESH_RESET);
        random_ops(40);
        wait_drained();

        repeat (2 * BLOCKS_DEF + 8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ refcount_block_table_gc_top.f @@
sv/rbtgc_pkg.sv
sv/rbtgc_ctrl.sv
sv/rbtgc_dp.sv
sv/refcount_block_table_gc_top.sv
tb/rbtgc_checker.sv
tb/tb_top.sv
